/* src/pfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// Types and constants shared by the position frame receiver files.
// ----------------------------------------------------------------------------
package pfr_pkg;

    // Frame layout constants
    localparam logic [7:0]  UPDATE_LEN  = 8'h06;
    localparam logic [7:0]  REPLY_LEN   = 8'h01;
    localparam logic [15:0] ANGLE_LIMIT = 16'd3600;
    localparam int          BUF_DEPTH   = 6;

    // Register reset values
    localparam logic [7:0] WAKE_RST   = 8'd85;
    localparam logic [7:0] UPDATE_RST = 8'd1;
    localparam logic [7:0] REPLY_RST  = 8'd2;

    // Register indexes on the config port
    localparam logic [1:0] REG_WAKE   = 2'd0;
    localparam logic [1:0] REG_UPDATE = 2'd1;
    localparam logic [1:0] REG_REPLY  = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_CMD  = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_ACCEPTED = 2'd1,
        EV_REJECTED = 2'd2,
        EV_REPLY    = 2'd3
    } t_event;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_REPLY  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
        logic [7:0] clear_reply_mask;
    } t_item;

    typedef struct packed {
        logic [7:0] wake_code;
        logic [7:0] update_code;
        logic [7:0] reply_code;
    } t_cfg;

    typedef struct packed {
        t_event             frame_event;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        heading;
        logic               available;
        logic [7:0]         reply_flags;
    } t_result;

endpackage

/* src/pfr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_if
// Valid/ready channels for received bytes and frame results.
// ----------------------------------------------------------------------------
interface pfr_in_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic [7:0] clear_reply_mask;

    modport source (output valid, byte_valid, rx_byte, clear_reply_mask, input ready);
    modport sink   (input valid, byte_valid, rx_byte, clear_reply_mask, output ready);
endinterface

interface pfr_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         frame_event;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [11:0]        heading;
    logic               available;
    logic [7:0]         reply_flags;

    modport source (output valid, frame_event, pos_x, pos_y, heading, available,
                    reply_flags, input ready);
    modport sink   (input valid, frame_event, pos_x, pos_y, heading, available,
                    reply_flags, output ready);
endinterface

/* src/pfr_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_regs
// APB-style register file holding the wake, update and reply codes.
// ----------------------------------------------------------------------------
module pfr_regs (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready,
    output pfr_pkg::t_cfg o_cfg
);
    import pfr_pkg::*;

    logic [7:0] r_wake;
    logic [7:0] r_update;
    logic [7:0] r_reply;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign reg_idx  = i_paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake   <= WAKE_RST;
            r_update <= UPDATE_RST;
            r_reply  <= REPLY_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WAKE:   r_wake   <= i_pwdata[7:0];
                REG_UPDATE: r_update <= i_pwdata[7:0];
                REG_REPLY:  r_reply  <= i_pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux, unmapped addresses read zero
    always_comb begin
        case (reg_idx)
            REG_WAKE:   o_prdata = {24'd0, r_wake};
            REG_UPDATE: o_prdata = {24'd0, r_update};
            REG_REPLY:  o_prdata = {24'd0, r_reply};
            default:    o_prdata = 32'd0;
        endcase
    end

    assign o_cfg.wake_code   = r_wake;
    assign o_cfg.update_code = r_update;
    assign o_cfg.reply_code  = r_reply;

endmodule

/* src/pfr_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_parser
// Frame parser state and one-step update logic; the result is the state
// after the byte, presented combinationally for the output register.
// ----------------------------------------------------------------------------
module pfr_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  pfr_pkg::t_item  i_item,
    input  pfr_pkg::t_cfg   i_cfg,
    output pfr_pkg::t_result o_result
);
    import pfr_pkg::*;

    t_phase             r_phase, n_phase;
    t_cmd               r_cmd, n_cmd;
    logic [2:0]         r_count, n_count;
    logic [7:0]         r_buf [BUF_DEPTH];
    logic [7:0]         n_buf [BUF_DEPTH];
    logic signed [15:0] r_x, n_x;
    logic signed [15:0] r_y, n_y;
    logic [11:0]        r_angle, n_angle;
    logic               r_avail, n_avail;
    logic [7:0]         r_reply, n_reply;
    t_event             ev;

    logic [7:0]  b;
    logic [7:0]  frame_len;
    logic [2:0]  count_inc;
    logic        done;
    logic [15:0] angle;

    assign b         = i_item.rx_byte;
    assign frame_len = (r_cmd == CMD_REPLY) ? REPLY_LEN : UPDATE_LEN;
    assign count_inc = r_count + 3'd1;
    assign done      = ({5'd0, count_inc} >= frame_len);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_item.byte_valid) begin
            case (r_phase)
                PH_HUNT: if (b == i_cfg.wake_code) n_phase = PH_CMD;
                PH_CMD: begin
                    if (b == i_cfg.update_code || b == i_cfg.reply_code) begin
                        n_phase = PH_LEN;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LEN:  n_phase = (b == frame_len) ? PH_DATA : PH_HUNT;
                PH_DATA: if (done) n_phase = PH_HUNT;
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // datapath: command, payload capture, frame completion, reply flags
    always_comb begin
        n_cmd   = r_cmd;
        n_count = r_count;
        n_buf   = r_buf;
        n_x     = r_x;
        n_y     = r_y;
        n_angle = r_angle;
        n_avail = r_avail;
        ev      = EV_NONE;
        angle   = 16'd0;
        // mask goes first so a reply in this step keeps its bit
        n_reply = r_reply & ~i_item.clear_reply_mask;
        if (i_item.byte_valid) begin
            case (r_phase)
                PH_HUNT: if (b == i_cfg.wake_code) n_count = 3'd0;
                PH_CMD: begin
                    if (b == i_cfg.update_code) begin
                        n_cmd = CMD_UPDATE;
                    end else if (b == i_cfg.reply_code) begin
                        n_cmd = CMD_REPLY;
                    end
                end
                PH_DATA: begin
                    for (int i = 0; i < BUF_DEPTH; i++) begin
                        if (r_count == 3'(i)) n_buf[i] = b;
                    end
                    n_count = count_inc;
                    if (done) begin
                        if (r_cmd == CMD_UPDATE) begin
                            // big-endian y, x, angle
                            angle = {n_buf[4], n_buf[5]};
                            if (angle < ANGLE_LIMIT) begin
                                n_y     = {n_buf[0], n_buf[1]};
                                n_x     = {n_buf[2], n_buf[3]};
                                n_angle = angle[11:0];
                                n_avail = 1'b1;
                                ev      = EV_ACCEPTED;
                            end else begin
                                n_avail = 1'b0;
                                ev      = EV_REJECTED;
                            end
                        end else begin
                            // reply numbers of eight and up set nothing
                            if (n_buf[0] < 8'd8) n_reply[n_buf[0][2:0]] = 1'b1;
                            ev = EV_REPLY;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cmd   <= CMD_UPDATE;
            r_count <= 3'd0;
            r_x     <= 16'sd0;
            r_y     <= 16'sd0;
            r_angle <= 12'd0;
            r_avail <= 1'b0;
            r_reply <= 8'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_count <= n_count;
            r_x     <= n_x;
            r_y     <= n_y;
            r_angle <= n_angle;
            r_avail <= n_avail;
            r_reply <= n_reply;
        end
    end

    // payload buffer, no reset
    always_ff @(posedge i_clk) begin
        if (i_fire) r_buf <= n_buf;
    end

    assign o_result.frame_event = ev;
    assign o_result.pos_x       = n_x;
    assign o_result.pos_y       = n_y;
    assign o_result.heading     = n_angle;
    assign o_result.available   = n_avail;
    assign o_result.reply_flags = n_reply;

endmodule

/* src/position_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_frame_receiver
// Parses wake/command/length/payload frames from a received byte stream,
// holding the last good position and a word of reply flags.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | contents
//  ---------+-----+----------------------+------------------------------------
//  i_rx     | in  | valid/ready          | byte_valid, rx_byte, clear mask
//  o_res    | out | valid/ready          | event, position, available, flags
//  apb      | in  | psel/penable, pready | wake, update, reply codes
//
//  One request per cycle sustained while o_res does not stall; a request
//  passes through the input register and then the result register, around
//  the parser's combinational update. Reset is synchronous and needs no sweep.
//  A stall on o_res holds the result and fills the input register; i_rx
//  ready drops only when both are full.
// ----------------------------------------------------------------------------
module position_frame_receiver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pfr_in_if.sink       i_rx,
    pfr_out_if.source    o_res,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);
    import pfr_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result res;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;
    logic    fire;
    logic    in_acc;

    pfr_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // flow control
    assign advance    = !r_out_valid || o_res.ready;
    assign fire       = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;
    assign in_acc     = i_rx.valid && i_rx.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.byte_valid       <= i_rx.byte_valid;
            r_in.rx_byte          <= i_rx.rx_byte;
            r_in.clear_reply_mask <= i_rx.clear_reply_mask;
        end
    end

    pfr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= fire || (r_out_valid && !o_res.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_out <= res;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.frame_event = r_out.frame_event;
    assign o_res.pos_x       = r_out.pos_x;
    assign o_res.pos_y       = r_out.pos_y;
    assign o_res.heading     = r_out.heading;
    assign o_res.available   = r_out.available;
    assign o_res.reply_flags = r_out.reply_flags;

endmodule

/* src/pfr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks on the result channel of the frame receiver.
// ----------------------------------------------------------------------------
module pfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_frame_event,
    input logic [11:0] i_heading,
    input logic        i_available,
    input logic [7:0]  i_reply_flags
);
    import pfr_pkg::*;

    // a stalled result holds its event and flags
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_frame_event) && $stable(i_reply_flags))
        else $error("stalled result changed");

    // accepted position always leaves the position available
    a_accept_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_event == EV_ACCEPTED |-> i_available)
        else $error("accepted frame without available");

    // rejected position always clears available
    a_reject_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_event == EV_REJECTED |-> !i_available)
        else $error("rejected frame with available set");

    // held heading stays in range
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> {4'd0, i_heading} < ANGLE_LIMIT)
        else $error("heading out of range");

endmodule

bind position_frame_receiver pfr_checker u_pfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_frame_event (o_res.frame_event),
    .i_heading     (o_res.heading),
    .i_available   (o_res.available),
    .i_reply_flags (o_res.reply_flags)
);
